// File: rtl/aram_pkg.sv
// Shared types, constants, the AES S-box table and the AES round of the arena mixer.
`timescale 1ns / 1ps

package aram_pkg;

  localparam int unsigned LANES_DEF        = 4;
  localparam int unsigned CHUNK_LENGTH_DEF = 128;
  localparam int unsigned LANE_IDX_W       = 4;
  localparam int unsigned CMD_Q_DEPTH      = 4;
  localparam int unsigned RES_Q_DEPTH      = 2;
  localparam int unsigned INDEX_W          = 41;
  localparam int unsigned REV_W            = 32;

  localparam logic [5:0] INDEX_BITS_RST = 6'd16;
  localparam logic [5:0] INDEX_BITS_MAX = 6'd32;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MIX  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic RK_INDEX = 1'b0;
  localparam logic RK_LANE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_MIX,
    CMD_READ
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  lane_select;
    logic [63:0] word_low;
    logic [63:0] word_high;
  } in_word_t;

  typedef struct packed {
    logic                 result_kind;
    logic [INDEX_W-1:0]   block_index;
    logic [63:0]          lane_low;
    logic [63:0]          lane_high;
  } out_word_t;

  typedef struct packed {
    cmd_op_e               op;
    logic [LANE_IDX_W-1:0] lane;
    logic                  lane_ok;
    logic                  last;
    logic [63:0]           key_low;
    logic [63:0]           key_high;
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c)   +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      m[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      m[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      m[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      m[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return m ^ k;
  endfunction

endpackage

// File: rtl/aes_round_arena_mixer.sv
// Top level of the AES round arena mixer.
//
// Input channel: push / full with in_data_i (opcode, lane_select, word_low, word_high).
// A word is taken at a clock edge with push high and full low. Opcode load writes a
// lane, mix runs one AES round on lane (count mod LANES) keyed by the word's two
// halves, read returns a lane. Every LANES*CHUNK_LENGTH mixes the block emits the
// next chunk's block index. Result channel: empty / pop with out_data_o.
// Throughput is one word per cycle while full stays low; the AES round on the lane
// store is the combinational step that sets it. A taken word's decoded command
// enters the command queue, executes into the staging register, then moves through
// the multiply by the chunk area into the result queue, whose head is out_data_o.
// index_bits must be written with cfg_we_i only while the block is idle; the block
// itself does not enforce this. Reset sets index_bits to 16.
// Reset empties both queues and clears the mix count; lane contents are undefined
// until loaded. When pop is held low the result queue fills, the back end stops,
// the command queue fills and full rises; no word is lost.
`timescale 1ns / 1ps

module aes_round_arena_mixer
  import aram_pkg::*;
#(
  parameter int unsigned LANES        = LANES_DEF,
  parameter int unsigned CHUNK_LENGTH = CHUNK_LENGTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_data_o
);

  logic [5:0] index_bits_q;
  logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t       cmd_in, cmd_out;
  logic       res_push, res_full;
  out_word_t  res_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= INDEX_BITS_RST;
    end else if (cfg_we_i) begin
      index_bits_q <= cfg_wdata_i;
    end
  end

  assign full = cmd_full;

  aram_front #(
    .LANES       (LANES),
    .CHUNK_LENGTH(CHUNK_LENGTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .cmd_full_i(cmd_full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  aram_fifo #(
    .T    (cmd_t),
    .DEPTH(CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  aram_back #(
    .LANES       (LANES),
    .CHUNK_LENGTH(CHUNK_LENGTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .index_bits_i(index_bits_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  aram_fifo #(
    .T    (out_word_t),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule

// File: rtl/aram_fifo.sv
// Small register queue used between front, back and result ports.
`timescale 1ns / 1ps

module aram_fifo
  import aram_pkg::*;
#(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/aram_front.sv
// Front end: accepts input words, decodes them and tags mixes with lane and chunk end.
`timescale 1ns / 1ps

module aram_front
  import aram_pkg::*;
#(
  parameter int unsigned LANES        = LANES_DEF,
  parameter int unsigned CHUNK_LENGTH = CHUNK_LENGTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t in_data_i,
  input  logic     cmd_full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  localparam int unsigned AREA = LANES * CHUNK_LENGTH;
  localparam int unsigned LW   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CW   = (AREA > 1) ? $clog2(AREA) : 1;
  localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);
  localparam logic [CW-1:0] LAST_BLK  = CW'(AREA - 1);
  localparam logic [4:0]    LANES_W   = 5'(LANES);

  logic [LW-1:0] lane_cnt_q, lane_cnt_d;
  logic [CW-1:0] blk_cnt_q, blk_cnt_d;
  logic          accept;
  logic          sel_ok;
  logic          keep;
  logic          is_mix;

  assign accept = push_i && !cmd_full_i;
  assign sel_ok = ({3'b000, in_data_i.lane_select} < LANES_W);
  assign is_mix = (in_data_i.opcode == OP_MIX);

  always_comb begin
    cmd_o          = '0;
    cmd_o.key_low  = in_data_i.word_low;
    cmd_o.key_high = in_data_i.word_high;
    cmd_o.lane_ok  = sel_ok;
    cmd_o.lane     = LANE_IDX_W'(in_data_i.lane_select);
    cmd_o.last     = 1'b0;
    keep           = 1'b0;
    case (in_data_i.opcode)
      OP_LOAD: begin
        cmd_o.op = CMD_LOAD;
        keep     = sel_ok;
      end
      OP_MIX: begin
        cmd_o.op      = CMD_MIX;
        cmd_o.lane    = LANE_IDX_W'(lane_cnt_q);
        cmd_o.lane_ok = 1'b1;
        cmd_o.last    = (blk_cnt_q == LAST_BLK);
        keep          = 1'b1;
      end
      OP_READ: begin
        cmd_o.op = CMD_READ;
        keep     = 1'b1;
      end
      default: begin
        cmd_o.op = CMD_LOAD;
        keep     = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = accept && keep;

  always_comb begin
    lane_cnt_d = lane_cnt_q;
    blk_cnt_d  = blk_cnt_q;
    if (accept && is_mix) begin
      lane_cnt_d = (lane_cnt_q == LAST_LANE) ? '0 : lane_cnt_q + 1'b1;
      blk_cnt_d  = (blk_cnt_q == LAST_BLK) ? '0 : blk_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_cnt_q <= '0;
      blk_cnt_q  <= '0;
    end else begin
      lane_cnt_q <= lane_cnt_d;
      blk_cnt_q  <= blk_cnt_d;
    end
  end

endmodule

// File: rtl/aram_back.sv
// Back end: lane scratchpad, AES round, index extraction and result staging.
`timescale 1ns / 1ps

module aram_back
  import aram_pkg::*;
#(
  parameter int unsigned LANES        = LANES_DEF,
  parameter int unsigned CHUNK_LENGTH = CHUNK_LENGTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [5:0] index_bits_i,
  input  cmd_t       cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  input  logic       res_full_i,
  output logic       res_push_o,
  output out_word_t  res_o
);

  localparam int unsigned AREA = LANES * CHUNK_LENGTH;
  localparam int unsigned LW   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned AW   = $clog2(AREA + 1);
  localparam int unsigned PW   = REV_W + AW;
  localparam logic [AW-1:0] AREA_C = AW'(AREA);

  typedef struct packed {
    logic             kind;
    logic [REV_W-1:0] rev;
    logic [63:0]      lane_low;
    logic [63:0]      lane_high;
  } stage_t;

  logic [63:0]   lane_lo_q [LANES];
  logic [63:0]   lane_hi_q [LANES];
  stage_t        stg_q, stg_d;
  logic          stg_vld_q, stg_vld_d;
  logic          stg_ready;
  logic          exec;
  logic          has_res;
  logic          lane_we;
  logic [LW-1:0] idx;
  logic [127:0]  cur;
  logic [127:0]  rnd;
  logic [127:0]  wdata;
  logic [63:0]   lane0_hi;
  logic [63:0]   rev_full;
  logic [5:0]    bits;
  logic [32:0]   mask;
  logic [PW-1:0] prod;

  assign stg_ready = !stg_vld_q || !res_full_i;
  assign exec      = !cmd_empty_i && stg_ready;
  assign cmd_pop_o = exec;

  assign idx = LW'(cmd_i.lane);
  assign cur = {lane_hi_q[idx], lane_lo_q[idx]};
  assign rnd = aes_round(cur, {cmd_i.key_high, cmd_i.key_low});

  always_comb begin
    lane_we = 1'b0;
    has_res = 1'b0;
    wdata   = {cmd_i.key_high, cmd_i.key_low};
    case (cmd_i.op)
      CMD_LOAD: begin
        lane_we = exec;
      end
      CMD_MIX: begin
        lane_we = exec;
        wdata   = rnd;
        has_res = cmd_i.last;
      end
      CMD_READ: begin
        has_res = 1'b1;
      end
      default: begin
        lane_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lane_we) begin
      lane_lo_q[idx] <= wdata[63:0];
      lane_hi_q[idx] <= wdata[127:64];
    end
  end

  assign lane0_hi = (lane_we && idx == '0) ? wdata[127:64] : lane_hi_q[0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev_full[8*(7-i) +: 8] = lane0_hi[8*i +: 8];
    end
  end

  assign bits = (index_bits_i > INDEX_BITS_MAX) ? INDEX_BITS_MAX : index_bits_i;
  assign mask = (33'd1 << bits) - 33'd1;

  always_comb begin
    stg_d = stg_q;
    if (cmd_i.op == CMD_READ) begin
      stg_d.kind      = RK_LANE;
      stg_d.rev       = '0;
      stg_d.lane_low  = cmd_i.lane_ok ? cur[63:0] : 64'd0;
      stg_d.lane_high = cmd_i.lane_ok ? cur[127:64] : 64'd0;
    end else begin
      stg_d.kind      = RK_INDEX;
      stg_d.rev       = rev_full[REV_W-1:0] & mask[REV_W-1:0];
      stg_d.lane_low  = '0;
      stg_d.lane_high = '0;
    end
  end

  always_comb begin
    stg_vld_d = stg_vld_q;
    if (exec) begin
      stg_vld_d = has_res;
    end else if (res_push_o) begin
      stg_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && has_res) begin
      stg_q <= stg_d;
    end
  end

  assign prod       = PW'(stg_q.rev) * PW'(AREA_C);
  assign res_push_o = stg_vld_q && !res_full_i;

  always_comb begin
    res_o             = '0;
    res_o.result_kind = stg_q.kind;
    res_o.block_index = INDEX_W'(prod);
    res_o.lane_low    = stg_q.lane_low;
    res_o.lane_high   = stg_q.lane_high;
  end

endmodule
